FILE: src/frame_deframer_size_parity_top_assert.svh
// assertion macros for the frame deframer
// used by frame_deframer_size_parity_top.sv, no other dependencies
`ifndef FRAME_DEFRAMER_SIZE_PARITY_TOP_ASSERT_SVH
`define FRAME_DEFRAMER_SIZE_PARITY_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked out of reset
`define FDSP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fdsp assertion failed");

// next-cycle implication, checked out of reset
`define FDSP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fdsp assertion failed");

`else

`define FDSP_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define FDSP_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: src/fdsp_pkg.sv
// shared constants and types for the frame deframer
// no dependencies
`timescale 1ns / 1ps

package fdsp_pkg;

  localparam int unsigned START_LEN = 2;
  localparam int unsigned END_LEN   = 2;
  localparam int unsigned ADDR_LEN  = 4;
  localparam int unsigned CHECK_LEN = 4;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned LEN_W    = 14;
  localparam int unsigned CNT_W    = 15;
  localparam int unsigned RUN_W    = 3;
  localparam int unsigned ROLE_W   = 3;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 14;

  typedef logic [BYTE_W-1:0]   byte_t;
  typedef logic [LEN_W-1:0]    len_t;
  typedef logic [CNT_W-1:0]    cnt_t;
  typedef logic [RUN_W-1:0]    run_t;
  typedef logic [ROLE_W-1:0]   role_t;
  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic [CFG_DAT_W-1:0] cfg_dat_t;
  typedef logic [1:0]          phase_t;

  // phase codes
  localparam phase_t PH_HUNT = 2'd0;
  localparam phase_t PH_HEAD = 2'd1;
  localparam phase_t PH_BODY = 2'd2;
  localparam phase_t PH_END  = 2'd3;

  // byte roles
  localparam role_t ROLE_DELIM   = 3'd0;
  localparam role_t ROLE_REQ     = 3'd1;
  localparam role_t ROLE_RESULT  = 3'd2;
  localparam role_t ROLE_SIZE_HI = 3'd3;
  localparam role_t ROLE_SIZE_LO = 3'd4;
  localparam role_t ROLE_ADDR    = 3'd5;
  localparam role_t ROLE_PAYLOAD = 3'd6;
  localparam role_t ROLE_CHECK   = 3'd7;

  // frame status codes
  localparam status_t ST_BUSY      = 3'd0;
  localparam status_t ST_OK        = 3'd1;
  localparam status_t ST_SHORT_RUN = 3'd2;
  localparam status_t ST_PARITY    = 3'd3;
  localparam status_t ST_TOO_LARGE = 3'd4;
  localparam status_t ST_BAD_END   = 3'd5;

  // configuration register indexes
  localparam cfg_idx_t REG_START_DELIM = 2'd0;
  localparam cfg_idx_t REG_END_DELIM   = 2'd1;
  localparam cfg_idx_t REG_MAX_PAYLOAD = 2'd2;

  localparam byte_t START_DELIM_RST = 8'hAA;
  localparam byte_t END_DELIM_RST   = 8'h55;
  localparam len_t  MAX_PAYLOAD_RST = 14'h3FFF;

  localparam run_t RUN_MAX = 3'd7;

  // xor of the eight 2-bit groups of the two size bytes
  function automatic logic [1:0] size_group_xor(input byte_t hi, input byte_t lo);
    return hi[1:0] ^ hi[3:2] ^ hi[5:4] ^ hi[7:6] ^ lo[1:0] ^ lo[3:2] ^ lo[5:4] ^ lo[7:6];
  endfunction

endpackage

FILE: src/fdsp_if.sv
// valid/ready channel interfaces of the frame deframer
// depends on fdsp_pkg
`timescale 1ns / 1ps

interface fdsp_in_if;
  logic             valid;
  logic             ready;
  fdsp_pkg::byte_t  rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface fdsp_out_if;
  logic              valid;
  logic              ready;
  fdsp_pkg::byte_t   data_byte;
  fdsp_pkg::role_t   byte_role;
  fdsp_pkg::status_t frame_status;
  fdsp_pkg::len_t    payload_len;
  logic              frame_end;

  modport source (output valid, output data_byte, output byte_role, output frame_status,
                  output payload_len, output frame_end, input ready);
  modport sink   (input valid, input data_byte, input byte_role, input frame_status,
                  input payload_len, input frame_end, output ready);
endinterface

interface fdsp_cfg_if;
  logic               valid;
  logic               ready;
  fdsp_pkg::cfg_idx_t index;
  fdsp_pkg::cfg_dat_t data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: src/frame_deframer_size_parity_top.sv
// frame deframer: start-run hunt, head decode, size parity and limit, end check
// depends on fdsp_pkg, fdsp_if.sv and frame_deframer_size_parity_top_assert.svh
// a result is presented in the cycle after its byte is accepted
// throughput: one byte per cycle while the output is not stalled, the frame state updates in the accepting cycle
// the single result register refills in the cycle it drains, so no bubbles
// reset (rst_n, synchronous): hunting, counters clear, configuration registers take defaults
`timescale 1ns / 1ps
`include "frame_deframer_size_parity_top_assert.svh"

module frame_deframer_size_parity_top (
  input  logic        clk,
  input  logic        rst_n,
  fdsp_in_if.sink     in_ch,
  fdsp_out_if.source  out_ch,
  fdsp_cfg_if.sink    cfg_ch
);
  import fdsp_pkg::*;

  localparam cnt_t ADDR_CNT  = cnt_t'(ADDR_LEN);
  localparam cnt_t CHECK_CNT = cnt_t'(CHECK_LEN);
  localparam cnt_t END_CNT   = cnt_t'(END_LEN);
  localparam run_t START_RUN = run_t'(START_LEN);

  // configuration
  byte_t start_delim_r;
  byte_t end_delim_r;
  len_t  max_payload_r;

  // frame state
  phase_t phase_r, phase_nxt;
  run_t   run_cnt_r, run_cnt_nxt;
  cnt_t   byte_cnt_r, byte_cnt_nxt;
  byte_t  size_hi_r, size_hi_nxt;
  len_t   len_r, len_nxt;
  logic   end_bad_r, end_bad_nxt;

  // result register
  logic    out_valid_r;
  byte_t   data_r;
  role_t   role_r, role_nxt;
  status_t status_r, status_nxt;
  len_t    out_len_r;
  logic    fend_r, fend_nxt;

  logic  in_acc;
  byte_t b;
  len_t  size_lo_len;
  cnt_t  cnt_inc;
  cnt_t  pay_end;
  cnt_t  total;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign b            = in_ch.rx_byte;

  assign size_lo_len = {size_hi_r[5:0], b};
  assign cnt_inc     = byte_cnt_r + cnt_t'(1);
  assign pay_end     = ADDR_CNT + cnt_t'(len_r);
  assign total       = pay_end + CHECK_CNT;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_delim_r <= START_DELIM_RST;
      end_delim_r   <= END_DELIM_RST;
      max_payload_r <= MAX_PAYLOAD_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_START_DELIM: start_delim_r <= cfg_ch.data[BYTE_W-1:0];
        REG_END_DELIM:   end_delim_r   <= cfg_ch.data[BYTE_W-1:0];
        REG_MAX_PAYLOAD: max_payload_r <= cfg_ch.data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_nxt    = phase_r;
    run_cnt_nxt  = run_cnt_r;
    byte_cnt_nxt = byte_cnt_r;
    size_hi_nxt  = size_hi_r;
    len_nxt      = len_r;
    end_bad_nxt  = end_bad_r;
    role_nxt     = ROLE_DELIM;
    status_nxt   = ST_BUSY;
    fend_nxt     = 1'b0;

    unique case (phase_r)
      PH_HEAD: begin
        if (byte_cnt_r == cnt_t'(1)) begin
          role_nxt     = ROLE_RESULT;
          byte_cnt_nxt = cnt_t'(2);
        end else if (byte_cnt_r == cnt_t'(2)) begin
          role_nxt     = ROLE_SIZE_HI;
          size_hi_nxt  = b;
          byte_cnt_nxt = cnt_t'(3);
        end else begin
          role_nxt = ROLE_SIZE_LO;
          len_nxt  = size_lo_len;
          if (size_group_xor(size_hi_r, b) != 2'b00) begin
            status_nxt = ST_PARITY;
            fend_nxt   = 1'b1;
          end else if (size_lo_len > max_payload_r) begin
            status_nxt = ST_TOO_LARGE;
            fend_nxt   = 1'b1;
          end else begin
            phase_nxt    = PH_BODY;
            byte_cnt_nxt = '0;
          end
        end
      end
      PH_BODY: begin
        if (byte_cnt_r < ADDR_CNT) begin
          role_nxt = ROLE_ADDR;
        end else if (byte_cnt_r < pay_end) begin
          role_nxt = ROLE_PAYLOAD;
        end else begin
          role_nxt = ROLE_CHECK;
        end
        byte_cnt_nxt = cnt_inc;
        if (cnt_inc >= total) begin
          phase_nxt    = PH_END;
          byte_cnt_nxt = '0;
          end_bad_nxt  = 1'b0;
        end
      end
      PH_END: begin
        byte_cnt_nxt = cnt_inc;
        if (cnt_inc >= END_CNT) begin
          status_nxt = (end_bad_r || (b != end_delim_r)) ? ST_BAD_END : ST_OK;
          fend_nxt   = 1'b1;
        end else if (b != end_delim_r) begin
          end_bad_nxt = 1'b1;
        end
      end
      PH_HUNT: begin
        if (b == start_delim_r) begin
          if (run_cnt_r < RUN_MAX) begin
            run_cnt_nxt = run_cnt_r + run_t'(1);
          end
        end else if (run_cnt_r < START_RUN) begin
          status_nxt = ST_SHORT_RUN;
          fend_nxt   = 1'b1;
        end else begin
          role_nxt     = ROLE_REQ;
          phase_nxt    = PH_HEAD;
          run_cnt_nxt  = '0;
          byte_cnt_nxt = cnt_t'(1);
          len_nxt      = '0;
          end_bad_nxt  = 1'b0;
        end
      end
      default: ;
    endcase

    // every frame end or abort goes back to hunting
    if (fend_nxt) begin
      phase_nxt    = PH_HUNT;
      run_cnt_nxt  = '0;
      byte_cnt_nxt = '0;
      end_bad_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HUNT;
      run_cnt_r   <= '0;
      byte_cnt_r  <= '0;
      size_hi_r   <= '0;
      len_r       <= '0;
      end_bad_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        phase_r    <= phase_nxt;
        run_cnt_r  <= run_cnt_nxt;
        byte_cnt_r <= byte_cnt_nxt;
        size_hi_r  <= size_hi_nxt;
        len_r      <= len_nxt;
        end_bad_r  <= end_bad_nxt;
      end
      if (in_acc) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      data_r    <= b;
      role_r    <= role_nxt;
      status_r  <= status_nxt;
      out_len_r <= len_nxt;
      fend_r    <= fend_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.data_byte    = data_r;
  assign out_ch.byte_role    = role_r;
  assign out_ch.frame_status = status_r;
  assign out_ch.payload_len  = out_len_r;
  assign out_ch.frame_end    = fend_r;

  // a frame end always carries a final status, and only then
  `FDSP_ASSERT_NOW(a_end_has_status, clk, rst_n, out_valid_r, fend_r == (status_r != ST_BUSY))
  // the end-delimiter count never reaches its limit while in the end phase
  `FDSP_ASSERT_NOW(a_end_cnt_range, clk, rst_n, phase_r == PH_END, byte_cnt_r < END_CNT)
  // hunting keeps the byte counter clear
  `FDSP_ASSERT_NOW(a_hunt_cnt_clear, clk, rst_n, phase_r == PH_HUNT, byte_cnt_r == '0)
  // a request code byte always opens the head
  `FDSP_ASSERT_NEXT(a_req_opens_head, clk, rst_n, in_acc && (role_nxt == ROLE_REQ),
                    phase_r == PH_HEAD && byte_cnt_r == cnt_t'(1))
  // after a frame end or abort the block is hunting with a cleared run
  `FDSP_ASSERT_NEXT(a_end_to_hunt, clk, rst_n, in_acc && fend_nxt,
                    phase_r == PH_HUNT && run_cnt_r == '0)

endmodule
